/* hw/rtl/heat_detector_median_rate_of_rise_top_assert.svh */
// ---------------------------------------------------------------------------
// Heat detector assertion macros
// Shared concurrent assertion forms for the heat detector RTL.
// ---------------------------------------------------------------------------
`ifndef HEAT_DETECTOR_MEDIAN_RATE_OF_RISE_TOP_ASSERT_SVH
`define HEAT_DETECTOR_MEDIAN_RATE_OF_RISE_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define HDMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is applied.
`define HDMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hdmr_pkg.sv */
// ---------------------------------------------------------------------------
// Heat detector package
// Widths, register codes, reset values and shared structs.
// ---------------------------------------------------------------------------
package hdmr_pkg;

	localparam int TEMP_W  = 16;
	localparam int LEVEL_W = 3;
	localparam int NEED_W  = 6;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int GROUP   = 8;
	localparam int PART_W  = 4;

	localparam logic [TEMP_W-1:0] FIRE_RST = 16'd58;
	localparam logic [NEED_W-1:0] NEED_RST = 6'd28;
	localparam logic [TEMP_W-1:0] RISE_RST = 16'd8;

	typedef enum logic [1:0] {
		REG_FIRE = 2'd0,
		REG_NEED = 2'd1,
		REG_RISE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TEMP_W-1:0] hot_limit;
		logic [NEED_W-1:0] high_count_needed;
		logic [TEMP_W-1:0] rise_threshold;
	} cfg_t;

	// Front-end result for one transaction.
	typedef struct packed {
		logic              ok;
		logic              chk;
		logic [TEMP_W-1:0] med;
	} front_t;

endpackage

/* hw/rtl/hdmr_cfg.sv */
// ---------------------------------------------------------------------------
// Heat detector configuration registers
// APB-style register file for the thresholds.
// ---------------------------------------------------------------------------
module hdmr_cfg import hdmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hot_limit         <= FIRE_RST;
			cfg_q.high_count_needed <= NEED_RST;
			cfg_q.rise_threshold    <= RISE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FIRE: cfg_q.hot_limit         <= pwdata[TEMP_W-1:0];
				REG_NEED: cfg_q.high_count_needed <= pwdata[NEED_W-1:0];
				REG_RISE: cfg_q.rise_threshold    <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FIRE: prdata = DATA_W'(cfg_q.hot_limit);
			REG_NEED: prdata = DATA_W'(cfg_q.high_count_needed);
			REG_RISE: prdata = DATA_W'(cfg_q.rise_threshold);
			default:  prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/hdmr_median.sv */
// ---------------------------------------------------------------------------
// Heat detector median network
// Rank-based median of the raw window; lower middle for even sizes.
// ---------------------------------------------------------------------------
module hdmr_median import hdmr_pkg::*; #(
	parameter int N = 5
) (
	input  logic [TEMP_W-1:0] win [N],
	output logic [TEMP_W-1:0] med
);

	localparam int RK_W = $clog2(N) + 1;
	localparam int MID  = (N - 1) / 2;

	logic [RK_W-1:0] rank [N];
	logic [N-1:0]    pick;

	// Ties rank by position so every entry gets a distinct rank.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < N; j++) begin
				if (j != i && (win[j] < win[i] || (j < i && win[j] == win[i])))
					rank[i] = rank[i] + RK_W'(1);
			end
			pick[i] = (rank[i] == RK_W'(MID));
		end
		med = '0;
		for (int i = 0; i < N; i++)
			med = med | (pick[i] ? win[i] : '0);
	end

endmodule

/* hw/rtl/hdmr_store.sv */
// ---------------------------------------------------------------------------
// Heat detector level store
// Per-level raw and smoothed shift lines, warm-up counters and median.
// ---------------------------------------------------------------------------
module hdmr_store import hdmr_pkg::*; #(
	parameter int NUM_LEVELS    = 5,
	parameter int RAW_WINDOW    = 5,
	parameter int SMOOTH_WINDOW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  logic [LEVEL_W-1:0] level,
	input  logic [TEMP_W-1:0]  temperature,
	input  logic [LEVEL_W-1:0] rd_level,
	output front_t             front,
	output logic [TEMP_W-1:0]  window [SMOOTH_WINDOW]
);

	localparam int WARMUP = RAW_WINDOW * SMOOTH_WINDOW;
	localparam int WU_W   = $clog2(WARMUP + 1);

	logic [TEMP_W-1:0]     raw_q    [NUM_LEVELS][RAW_WINDOW];
	logic [TEMP_W-1:0]     smooth_q [NUM_LEVELS][SMOOTH_WINDOW];
	logic [WU_W-1:0]       warm_q   [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] wr_hit;
	logic [NUM_LEVELS-1:0] rd_hit;
	logic [TEMP_W-1:0]     nw [RAW_WINDOW];
	logic [WU_W-1:0]       warm_sel;
	logic [TEMP_W-1:0]     med;

	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			wr_hit[l] = (32'(level) == l);
			rd_hit[l] = (32'(rd_level) == l);
		end
		// New raw window: sample at the head, older entries move down.
		nw[0] = temperature;
		for (int i = 1; i < RAW_WINDOW; i++) begin
			nw[i] = '0;
			for (int l = 0; l < NUM_LEVELS; l++)
				nw[i] = nw[i] | (wr_hit[l] ? raw_q[l][i-1] : '0);
		end
		warm_sel = '0;
		for (int l = 0; l < NUM_LEVELS; l++)
			warm_sel = warm_sel | (wr_hit[l] ? warm_q[l] : '0);
		for (int i = 0; i < SMOOTH_WINDOW; i++) begin
			window[i] = '0;
			for (int l = 0; l < NUM_LEVELS; l++)
				window[i] = window[i] | (rd_hit[l] ? smooth_q[l][i] : '0);
		end
	end

	hdmr_median #(.N(RAW_WINDOW)) u_median (
		.win (nw),
		.med (med)
	);

	always_comb begin
		front.ok  = |wr_hit;
		front.chk = (warm_sel == '0);
		front.med = med;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				for (int i = 0; i < RAW_WINDOW; i++)
					raw_q[l][i] <= '0;
				for (int i = 0; i < SMOOTH_WINDOW; i++)
					smooth_q[l][i] <= '0;
				warm_q[l] <= WU_W'(WARMUP);
			end
		end else if (commit) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				if (wr_hit[l]) begin
					for (int i = 0; i < RAW_WINDOW; i++)
						raw_q[l][i] <= nw[i];
					smooth_q[l][0] <= med;
					for (int i = 1; i < SMOOTH_WINDOW; i++)
						smooth_q[l][i] <= smooth_q[l][i-1];
					if (warm_q[l] != '0)
						warm_q[l] <= warm_q[l] - WU_W'(1);
				end
			end
		end
	end

endmodule

/* hw/rtl/hdmr_check.sv */
// ---------------------------------------------------------------------------
// Heat detector window check
// Threshold compares with grouped partial counts, and the rise test.
// ---------------------------------------------------------------------------
module hdmr_check import hdmr_pkg::*; #(
	parameter int SMOOTH_WINDOW = 32,
	localparam int NGROUP = (SMOOTH_WINDOW + GROUP - 1) / GROUP
) (
	input  logic [TEMP_W-1:0] window [SMOOTH_WINDOW],
	input  cfg_t              cfg,
	output logic [PART_W-1:0] part [NGROUP],
	output logic              rise_hit
);

	logic [SMOOTH_WINDOW-1:0] high;
	logic signed [TEMP_W:0]   diff;

	always_comb begin
		for (int i = 0; i < SMOOTH_WINDOW; i++)
			high[i] = (window[i] >= cfg.hot_limit);
		for (int g = 0; g < NGROUP; g++) begin
			part[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < SMOOTH_WINDOW)
					part[g] = part[g] + PART_W'(high[g * GROUP + k]);
			end
		end
		// Newest minus oldest, signed.
		diff     = $signed({1'b0, window[0]}) - $signed({1'b0, window[SMOOTH_WINDOW-1]});
		rise_hit = (diff >= $signed({1'b0, cfg.rise_threshold}));
	end

endmodule

/* hw/rtl/heat_detector_median_rate_of_rise_top.sv */
// ---------------------------------------------------------------------------
// Heat detector with median smoothing and rate-of-rise test
//
// Usage: each sample transaction carries a level and a raw temperature.
// The level's raw window takes the sample, its median enters the level's
// smoothed window, and after the warm-up each level checks the count of
// smoothed values at or above the high-temperature limit and the
// newest-minus-oldest rise. Either test latches the shared alarm; later
// samples are ignored.
// Channels: sample (valid/stall, level + temperature) in, result
// (valid/stall, alarm + detected_now + smoothed_value) out, thresholds
// through the APB-style port (write only while the block is idle).
// Throughput: one transaction per cycle unless the result stalls; the four
// pipeline registers (input, median/store, compare, result) hold one each.
// Reset: windows clear to zero, warm-up counters load the window product,
// thresholds load their defaults, the alarm clears, the pipeline empties.
// Stall: a stalled result holds; upstream stages keep filling bubbles and
// sample_stall rises only once every stage is occupied.
// ---------------------------------------------------------------------------
`include "heat_detector_median_rate_of_rise_top_assert.svh"

module heat_detector_median_rate_of_rise_top import hdmr_pkg::*; #(
	parameter int NUM_LEVELS    = 5,
	parameter int RAW_WINDOW    = 5,
	parameter int SMOOTH_WINDOW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample channel
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [LEVEL_W-1:0] level,
	input  logic [TEMP_W-1:0]  temperature,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic               alarm,
	output logic               detected_now,
	output logic [TEMP_W-1:0]  smoothed_value,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int NGROUP = (SMOOTH_WINDOW + GROUP - 1) / GROUP;
	localparam int CNT_W  = $clog2(SMOOTH_WINDOW + 1);

	cfg_t cfg;

	// Stage valids and handshake readiness
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy_out;
	logic mv1, mv3;

	// Stage 1: registered sample
	logic [LEVEL_W-1:0] level_s1;
	logic [TEMP_W-1:0]  temp_s1;

	// Stage 2: median and warm-up status, level for the window read
	front_t             front;
	front_t             front_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic [TEMP_W-1:0]  window [SMOOTH_WINDOW];

	// Stage 3: partial high counts and rise test
	logic [PART_W-1:0]  part [NGROUP];
	logic               rise_hit;
	front_t             front_s3;
	logic [PART_W-1:0]  part_s3 [NGROUP];
	logic               rise_s3;

	// Decision and result
	logic [CNT_W-1:0]   cnt;
	logic               hit;
	logic               alarm_q;
	logic               alarm_out_q;
	logic               det_q;
	logic [TEMP_W-1:0]  smooth_out_q;

	hdmr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Each stage moves on when the next one is empty or moving too.
	assign rdy_out      = !out_valid_q || !result_stall;
	assign rdy3         = !valid_s3 || rdy_out;
	assign rdy2         = !valid_s2 || rdy3;
	assign rdy1         = !valid_s1 || rdy2;
	assign mv1          = valid_s1 && rdy2;
	assign mv3          = valid_s3 && rdy_out;
	assign sample_stall = !rdy1;

	// Level state commits once, as the transaction leaves stage 1, so the
	// next transaction in stage 1 always sees the updated windows. Stage 2
	// reads the smoothed window after this transaction's own shift.
	hdmr_store #(
		.NUM_LEVELS    (NUM_LEVELS),
		.RAW_WINDOW    (RAW_WINDOW),
		.SMOOTH_WINDOW (SMOOTH_WINDOW)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (mv1),
		.level       (level_s1),
		.temperature (temp_s1),
		.rd_level    (level_s2),
		.front       (front),
		.window      (window)
	);

	hdmr_check #(.SMOOTH_WINDOW(SMOOTH_WINDOW)) u_check (
		.window   (window),
		.cfg      (cfg),
		.part     (part),
		.rise_hit (rise_hit)
	);

	// Sum the partial counts and decide. The alarm latch is checked here,
	// in order, so state updates made behind a detecting transaction are
	// harmless: nothing reads them once the alarm is set.
	always_comb begin
		cnt = '0;
		for (int g = 0; g < NGROUP; g++)
			cnt = cnt + CNT_W'(part_s3[g]);
		hit = front_s3.ok && front_s3.chk && !alarm_q &&
		      ((NEED_W'(cnt) >= cfg.high_count_needed) || rise_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			alarm_q     <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= sample_valid;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_s3 <= valid_s2;
			if (rdy_out)
				out_valid_q <= valid_s3;
			if (mv3 && hit)
				alarm_q <= 1'b1;
		end
	end

	// Payload registers: load whenever the stage may advance.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			level_s1 <= level;
			temp_s1  <= temperature;
		end
		if (rdy2) begin
			front_s2 <= front;
			level_s2 <= level_s1;
		end
		if (rdy3) begin
			front_s3 <= front_s2;
			part_s3  <= part;
			rise_s3  <= rise_hit;
		end
		if (rdy_out) begin
			alarm_out_q  <= alarm_q || hit;
			det_q        <= hit;
			smooth_out_q <= (front_s3.ok && !alarm_q) ? front_s3.med : '0;
		end
	end

	assign result_valid   = out_valid_q;
	assign alarm          = alarm_out_q;
	assign detected_now   = det_q;
	assign smoothed_value = smooth_out_q;

	`HDMR_ASSERT_NOW(a_det_sets_alarm, clk, arst_n, result_valid && detected_now, alarm,
		"detection reported without the alarm")
	`HDMR_ASSERT_NOW(a_ignored_zero, clk, arst_n, result_valid && alarm && !detected_now,
		smoothed_value == '0, "ignored transaction carries a smoothed value")
	`HDMR_ASSERT_NOW(a_stall_full, clk, arst_n, sample_stall,
		valid_s1 && valid_s2 && valid_s3 && out_valid_q, "sample stalled with a free stage")
	`HDMR_ASSERT_NEXT(a_single_det, clk, arst_n, result_valid && detected_now && !result_stall,
		!(result_valid && detected_now), "second detection after the alarm latched")

endmodule
